[src/ecal_pkg.sv]
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared widths, constants, microcode types and calendar helper functions
// for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

  // Field widths
  localparam int EPOCH_W = 32;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int WDAY_W  = 3;
  localparam int MDAY_W  = 5;
  localparam int MON_W   = 4;
  localparam int YOFF_W  = 8;

  // Day count since the epoch stays below 2^17 for any 32-bit input
  localparam int DAYS_W  = 17;
  localparam int YEAR_W  = 12;
  localparam int YLEN_W  = 9;

  // Constant divider: remainder width and bits retired per step
  localparam int REM_W      = 6;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = EPOCH_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Microcode address width
  localparam int UPC_W = 4;

  // Calendar constants
  localparam logic [REM_W-1:0]  SECS_PER_MIN   = REM_W'(60);
  localparam logic [REM_W-1:0]  MINS_PER_HOUR  = REM_W'(60);
  localparam logic [REM_W-1:0]  HOURS_PER_DAY  = REM_W'(24);
  localparam logic [REM_W-1:0]  DAYS_PER_WEEK  = REM_W'(7);
  localparam logic [YLEN_W-1:0] DAYS_LEAP_YEAR = YLEN_W'(366);
  localparam logic [YLEN_W-1:0] DAYS_YEAR      = YLEN_W'(365);
  localparam int                EPOCH_YEAR     = 1970;
  // 1970-01-01 was a Thursday: weekday index 4 counting Sunday as 0
  localparam int                EPOCH_WDAY_OFS = 4;
  localparam logic [MON_W-1:0]  MON_JAN        = MON_W'(0);
  localparam logic [MON_W-1:0]  MON_FEB        = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_DEC        = MON_W'(11);
  localparam logic [MDAY_W-1:0] FEB_LEAP_DAYS  = MDAY_W'(29);
  localparam logic [MDAY_W-1:0] FEB_DAYS       = MDAY_W'(28);

  // Century years reachable by an 8-bit offset that are not divisible by 400
  localparam logic [YEAR_W-1:0] YEAR_CENT_A = YEAR_W'(2100);
  localparam logic [YEAR_W-1:0] YEAR_CENT_B = YEAR_W'(2200);

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SAVE_SEC,
    OP_SAVE_MIN,
    OP_SAVE_HR,
    OP_SAVE_WD,
    OP_YEAR,
    OP_MONTH,
    OP_FINISH
  } ecal_op_e;

  // Divisor select for the constant divider
  typedef enum logic [1:0] {
    DSEL_60_SEC,
    DSEL_60_MIN,
    DSEL_24,
    DSEL_7
  } ecal_dsel_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_MORE,
    COND_YEAR_FITS,
    COND_MON_FITS,
    COND_OUT_FREE
  } ecal_cond_e;

  typedef struct packed {
    ecal_op_e         op;
    ecal_dsel_e       dsel;
    ecal_cond_e       cond;
    logic [UPC_W-1:0] target;
  } ecal_ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic div_more;
    logic year_fits;
    logic mon_fits;
    logic out_free;
  } ecal_flags_t;

  typedef struct packed {
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [WDAY_W-1:0] weekday;
    logic [MDAY_W-1:0] day_of_month;
    logic [MON_W-1:0]  month_number;
    logic [YOFF_W-1:0] year_offset;
  } ecal_result_t;

  // Gregorian leap rule for a year given as offset from the epoch year
  function automatic logic is_leap(input logic [YOFF_W-1:0] yoff);
    logic [YEAR_W-1:0] year;
    year = YEAR_W'(EPOCH_YEAR) + YEAR_W'(yoff);
    return (year[1:0] == 2'd0) && (year != YEAR_CENT_A) && (year != YEAR_CENT_B);
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic leap);
    logic [MDAY_W-1:0] len;
    case (mon)
      4'd0:    len = MDAY_W'(31);
      4'd1:    len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
      4'd2:    len = MDAY_W'(31);
      4'd3:    len = MDAY_W'(30);
      4'd4:    len = MDAY_W'(31);
      4'd5:    len = MDAY_W'(30);
      4'd6:    len = MDAY_W'(31);
      4'd7:    len = MDAY_W'(31);
      4'd8:    len = MDAY_W'(30);
      4'd9:    len = MDAY_W'(31);
      4'd10:   len = MDAY_W'(30);
      4'd11:   len = MDAY_W'(31);
      default: len = MDAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

[src/ecal_in_if.sv]
// ----------------------------------------------------------------------------
// ecal_in_if
// Input channel: one epoch second count per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecal_in_if;
  import ecal_pkg::*;

  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);

endinterface

[src/ecal_out_if.sv]
// ----------------------------------------------------------------------------
// ecal_out_if
// Output channel: broken-down calendar fields, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecal_out_if;
  import ecal_pkg::*;

  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  second;
  logic [MIN_W-1:0]  minute;
  logic [HOUR_W-1:0] hour;
  logic [WDAY_W-1:0] weekday;
  logic [MDAY_W-1:0] day_of_month;
  logic [MON_W-1:0]  month_number;
  logic [YOFF_W-1:0] year_offset;

  modport source (output valid, output second, output minute, output hour,
                  output weekday, output day_of_month, output month_number,
                  output year_offset, input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input weekday, input day_of_month, input month_number,
                  input year_offset, output ready);

endinterface

[src/ecal_useq.sv]
// ----------------------------------------------------------------------------
// ecal_useq
// Microcode sequencer: program ROM, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module ecal_useq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  ecal_pkg::ecal_flags_t flags_i,
  output ecal_pkg::ecal_ucode_t ctrl_o
);
  import ecal_pkg::*;

  localparam logic [UPC_W-1:0] STEP_IDLE    = UPC_W'(0);
  localparam logic [UPC_W-1:0] STEP_DIV_SEC = UPC_W'(1);
  localparam logic [UPC_W-1:0] STEP_SEC     = UPC_W'(2);
  localparam logic [UPC_W-1:0] STEP_DIV_MIN = UPC_W'(3);
  localparam logic [UPC_W-1:0] STEP_MIN     = UPC_W'(4);
  localparam logic [UPC_W-1:0] STEP_DIV_HR  = UPC_W'(5);
  localparam logic [UPC_W-1:0] STEP_HR      = UPC_W'(6);
  localparam logic [UPC_W-1:0] STEP_DIV_WD  = UPC_W'(7);
  localparam logic [UPC_W-1:0] STEP_WD      = UPC_W'(8);
  localparam logic [UPC_W-1:0] STEP_YEAR    = UPC_W'(9);
  localparam logic [UPC_W-1:0] STEP_MONTH   = UPC_W'(10);
  localparam logic [UPC_W-1:0] STEP_FINISH  = UPC_W'(11);
  localparam logic [UPC_W-1:0] STEP_STALL   = UPC_W'(12);

  function automatic ecal_ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ecal_ucode_t w;
    case (addr)
      STEP_IDLE:    w = '{OP_LOAD,     DSEL_60_SEC, COND_NO_INPUT,  STEP_IDLE};
      STEP_DIV_SEC: w = '{OP_DIV,      DSEL_60_SEC, COND_DIV_MORE,  STEP_DIV_SEC};
      STEP_SEC:     w = '{OP_SAVE_SEC, DSEL_60_SEC, COND_NEVER,     STEP_IDLE};
      STEP_DIV_MIN: w = '{OP_DIV,      DSEL_60_MIN, COND_DIV_MORE,  STEP_DIV_MIN};
      STEP_MIN:     w = '{OP_SAVE_MIN, DSEL_60_MIN, COND_NEVER,     STEP_IDLE};
      STEP_DIV_HR:  w = '{OP_DIV,      DSEL_24,     COND_DIV_MORE,  STEP_DIV_HR};
      STEP_HR:      w = '{OP_SAVE_HR,  DSEL_24,     COND_NEVER,     STEP_IDLE};
      STEP_DIV_WD:  w = '{OP_DIV,      DSEL_7,      COND_DIV_MORE,  STEP_DIV_WD};
      STEP_WD:      w = '{OP_SAVE_WD,  DSEL_7,      COND_NEVER,     STEP_IDLE};
      STEP_YEAR:    w = '{OP_YEAR,     DSEL_7,      COND_YEAR_FITS, STEP_YEAR};
      STEP_MONTH:   w = '{OP_MONTH,    DSEL_7,      COND_MON_FITS,  STEP_MONTH};
      STEP_FINISH:  w = '{OP_FINISH,   DSEL_7,      COND_OUT_FREE,  STEP_IDLE};
      STEP_STALL:   w = '{OP_NOP,      DSEL_7,      COND_ALWAYS,    STEP_FINISH};
      default:      w = '{OP_NOP,      DSEL_7,      COND_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

  logic [UPC_W-1:0] upc_q, upc_d;
  ecal_ucode_t      uw;
  logic             jump;

  assign uw     = ucode_rom(upc_q);
  assign ctrl_o = uw;

  always_comb begin
    case (uw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !in_valid_i;
      COND_DIV_MORE:  jump = flags_i.div_more;
      COND_YEAR_FITS: jump = flags_i.year_fits;
      COND_MON_FITS:  jump = flags_i.mon_fits;
      COND_OUT_FREE:  jump = flags_i.out_free;
      default:        jump = 1'b0;
    endcase
    upc_d = jump ? uw.target : upc_q + UPC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[src/ecal_dpath.sv]
// ----------------------------------------------------------------------------
// ecal_dpath
// Datapath: constant divider retiring four quotient bits a cycle, year and
// month subtractor, working registers and the output register.
// ----------------------------------------------------------------------------
module ecal_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ecal_pkg::ecal_ucode_t     ctrl_i,
  input  logic                      in_take_i,
  input  logic [ecal_pkg::EPOCH_W-1:0] epoch_seconds_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output ecal_pkg::ecal_result_t    result_o,
  output ecal_pkg::ecal_flags_t     flags_o
);
  import ecal_pkg::*;

  // Control state
  logic                 out_valid_q, out_valid_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  // Working registers
  logic [EPOCH_W-1:0] x_q, x_d;
  logic [REM_W-1:0]   r_q, r_d;
  logic [DAYS_W-1:0]  days_q, days_d;
  logic [YOFF_W-1:0]  yoff_q, yoff_d;
  logic [MON_W-1:0]   mon_q, mon_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [MIN_W-1:0]   min_q, min_d;
  logic [HOUR_W-1:0]  hr_q, hr_d;
  logic [WDAY_W-1:0]  wd_q, wd_d;
  ecal_result_t       out_q, out_d;

  logic [REM_W-1:0]   divisor;
  logic [REM_W-1:0]   div_rem;
  logic [EPOCH_W-1:0] div_quo;
  logic [REM_W:0]     div_part;

  logic               leap;
  logic [YLEN_W-1:0]  ylen;
  logic [MDAY_W-1:0]  mlen;
  logic               year_fits;
  logic               mon_fits;
  logic               out_free;

  always_comb begin
    case (ctrl_i.dsel)
      DSEL_60_SEC: divisor = SECS_PER_MIN;
      DSEL_60_MIN: divisor = MINS_PER_HOUR;
      DSEL_24:     divisor = HOURS_PER_DAY;
      DSEL_7:      divisor = DAYS_PER_WEEK;
      default:     divisor = DAYS_PER_WEEK;
    endcase
  end

  // Restoring division, MSB first; quotient shifts into x, remainder in r
  always_comb begin
    div_rem  = r_q;
    div_quo  = x_q;
    div_part = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_part = {div_rem, div_quo[EPOCH_W-1]};
      div_quo  = {div_quo[EPOCH_W-2:0], 1'b0};
      if (div_part >= {1'b0, divisor}) begin
        div_rem    = REM_W'(div_part - {1'b0, divisor});
        div_quo[0] = 1'b1;
      end else begin
        div_rem = div_part[REM_W-1:0];
      end
    end
  end

  assign leap      = is_leap(yoff_q);
  assign ylen      = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
  assign mlen      = month_len(mon_q, leap);
  assign year_fits = days_q >= DAYS_W'(ylen);
  // December always absorbs what is left of the year
  assign mon_fits  = (mon_q != MON_DEC) && (days_q >= DAYS_W'(mlen));
  assign out_free  = !out_valid_q || out_ready_i;

  assign flags_o.div_more  = cnt_q != DIV_CNT_W'(DIV_STEPS - 1);
  assign flags_o.year_fits = year_fits;
  assign flags_o.mon_fits  = mon_fits;
  assign flags_o.out_free  = out_free;

  always_comb begin
    x_d         = x_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    days_d      = days_q;
    yoff_d      = yoff_q;
    mon_d       = mon_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hr_d        = hr_q;
    wd_d        = wd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (ctrl_i.op)
      OP_LOAD: begin
        if (in_take_i) begin
          x_d    = epoch_seconds_i;
          r_d    = '0;
          cnt_d  = '0;
          yoff_d = '0;
          mon_d  = MON_JAN;
        end
      end
      OP_DIV: begin
        x_d   = div_quo;
        r_d   = div_rem;
        cnt_d = cnt_q + DIV_CNT_W'(1);
      end
      OP_SAVE_SEC: begin
        sec_d = SEC_W'(r_q);
        r_d   = '0;
      end
      OP_SAVE_MIN: begin
        min_d = MIN_W'(r_q);
        r_d   = '0;
      end
      OP_SAVE_HR: begin
        // x now holds whole days; load days plus the epoch weekday for mod 7
        hr_d   = HOUR_W'(r_q);
        days_d = x_q[DAYS_W-1:0];
        x_d    = EPOCH_W'(x_q[DAYS_W-1:0]) + EPOCH_W'(EPOCH_WDAY_OFS);
        r_d    = '0;
      end
      OP_SAVE_WD: begin
        wd_d = WDAY_W'(r_q) + WDAY_W'(1);
      end
      OP_YEAR: begin
        if (year_fits) begin
          days_d = days_q - DAYS_W'(ylen);
          yoff_d = yoff_q + YOFF_W'(1);
        end
      end
      OP_MONTH: begin
        if (mon_fits) begin
          days_d = days_q - DAYS_W'(mlen);
          mon_d  = mon_q + MON_W'(1);
        end
      end
      OP_FINISH: begin
        if (out_free) begin
          out_d.second       = sec_q;
          out_d.minute       = min_q;
          out_d.hour         = hr_q;
          out_d.weekday      = wd_q;
          out_d.day_of_month = MDAY_W'(days_q[MDAY_W-1:0]) + MDAY_W'(1);
          out_d.month_number = mon_q + MON_W'(1);
          out_d.year_offset  = yoff_q;
          out_valid_d        = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    days_q <= days_d;
    yoff_q <= yoff_d;
    mon_q  <= mon_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hr_q   <= hr_d;
    wd_q   <= wd_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

[src/epoch_seconds_to_calendar_unit.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Breaks a 32-bit local-time epoch second count into calendar fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries epoch_seconds; out_o carries second, minute, hour, weekday
//   (Sunday = 1), day_of_month, month_number and year_offset from 1970.
//   Both channels use valid/ready; an item moves when both are high.
//   One item is converted at a time by a microcoded sequencer. in_i.ready is
//   high only in the idle step. A conversion runs four divisions, each of
//   8 steps of 4 quotient bits and one save step, one year step per year
//   walked plus one, one month step per month walked plus one, and a finish
//   step, after which the sequencer returns to idle to take the next item.
//   The result sits in an output register, so the next item is taken and
//   worked on while the previous result waits; if the receiver still stalls
//   at the finish step, the sequencer alternates between the finish and
//   stall steps until the register frees. Reset (rst_ni low, asynchronous)
//   returns the sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecal_in_if.sink     in_i,
  ecal_out_if.source  out_o
);
  import ecal_pkg::*;

  ecal_ucode_t  ctrl;
  ecal_flags_t  flags;
  ecal_result_t result;
  logic         in_take;

  assign in_i.ready = (ctrl.op == OP_LOAD);
  assign in_take    = in_i.valid && in_i.ready;

  ecal_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  ecal_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .in_take_i       (in_take),
    .epoch_seconds_i (in_i.epoch_seconds),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .result_o        (result),
    .flags_o         (flags)
  );

  assign out_o.second       = result.second;
  assign out_o.minute       = result.minute;
  assign out_o.hour         = result.hour;
  assign out_o.weekday      = result.weekday;
  assign out_o.day_of_month = result.day_of_month;
  assign out_o.month_number = result.month_number;
  assign out_o.year_offset  = result.year_offset;

  // An accepted item starts the seconds division on the next cycle
  a_take_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (ctrl.op == OP_DIV) && (ctrl.dsel == DSEL_60_SEC))
    else $error("accepted item did not start the seconds division");

  // A new result appears only right after the finish step
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.op == OP_FINISH))
    else $error("result appeared outside the finish step");

  // The finish step with a free output register always publishes a result
  a_finish_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_FINISH) && flags.out_free |=> out_o.valid)
    else $error("finish step did not load the output register");

endmodule
